/* sv/ucl_pkg.sv */
// Shared constants, tables and types for the serial command line parser.
package ucl_pkg;

   // Line buffer capacity; the last slot is never filled
   localparam int LINE_CAPACITY_DEFAULT = 64;

   // Number of recognized line prefixes and the byte slots per prefix text
   localparam int PREFIX_COUNT = 5;
   localparam int PREFIX_SLOTS = 16;

   // Prefix order: MODE, PUMP, FAN, WDOW, THRESH
   localparam logic [2:0] PREFIX_MODE   = 3'd0;
   localparam logic [2:0] PREFIX_PUMP   = 3'd1;
   localparam logic [2:0] PREFIX_FAN    = 3'd2;
   localparam logic [2:0] PREFIX_WDOW   = 3'd3;
   localparam logic [2:0] PREFIX_THRESH = 3'd4;
   localparam logic [2:0] PREFIX_NONE   = 3'd5;

   // Command codes on the result channel
   localparam logic [3:0] CODE_AUTO          = 4'd0;
   localparam logic [3:0] CODE_MANUAL        = 4'd1;
   localparam logic [3:0] CODE_PUMP_ON       = 4'd2;
   localparam logic [3:0] CODE_PUMP_OFF      = 4'd3;
   localparam logic [3:0] CODE_FAN_ON        = 4'd4;
   localparam logic [3:0] CODE_FAN_OFF       = 4'd5;
   localparam logic [3:0] CODE_WINDOW_OPEN   = 4'd6;
   localparam logic [3:0] CODE_WINDOW_CLOSE  = 4'd7;
   localparam logic [3:0] CODE_SET_THRESHOLD = 4'd8;

   // Special bytes
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Prefix text, padded with zero bytes
   localparam logic [7:0] PREFIX_TEXT [0:PREFIX_COUNT-1][0:PREFIX_SLOTS-1] = '{
      '{"C", "M", "D", ":", "M", "O", "D", "E", ":", 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"C", "M", "D", ":", "P", "U", "M", "P", ":", 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"C", "M", "D", ":", "F", "A", "N", ":", 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"C", "M", "D", ":", "W", "D", "O", "W", ":", 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"C", "M", "D", ":", "T", "H", "R", "E", "S", "H", ":",
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };
   localparam logic [3:0] PREFIX_LEN [0:PREFIX_COUNT-1] =
      '{4'd9, 4'd9, 4'd8, 4'd9, 4'd11};

   // Keywords that select the first of the two states
   localparam logic [7:0] KEYWORD_TEXT [0:3][0:3] = '{
      '{"A", "U", "T", "O"},
      '{"O", "N", 8'h00, 8'h00},
      '{"O", "N", 8'h00, 8'h00},
      '{"O", "P", "E", "N"}
   };
   localparam logic [2:0] KEYWORD_LEN [0:3] = '{3'd4, 3'd2, 3'd2, 3'd4};

   // Two-number parse steps
   typedef enum logic [6:0] {
      NUM_LEAD1  = 7'b000_0001,
      NUM_SIGN1  = 7'b000_0010,
      NUM_DIGIT1 = 7'b000_0100,
      NUM_LEAD2  = 7'b000_1000,
      NUM_SIGN2  = 7'b001_0000,
      NUM_DIGIT2 = 7'b010_0000,
      NUM_DONE   = 7'b100_0000
   } num_phase_type;

   // One result word
   typedef struct packed {
      logic [7:0] threshold_high;
      logic [7:0] threshold_low;
      logic [3:0] command;
   } result_type;

endpackage

/* sv/uart_command_line_parser_top.sv */
// Serial command line parser: line assembly, prefix/keyword/number matching, output buffer.
//
// Feed received bytes on the req_ channel, one word per cycle; every byte is taken
// in the cycle it is offered unless two results are already waiting. Matching of
// prefix, keyword and numbers is done on the fly in one pass per byte. A newline that
// completes a recognized line has its command registered into the rsp_ output
// register, or into the skid entry if that register is still held. The result side has an
// output register plus one skid entry, so input stalls only when both hold
// results that the consumer has not yet taken. Carriage returns are dropped,
// lines keep at most LINE_CAPACITY-1 bytes, and no clearing pass is needed.
module uart_command_line_parser_top #(
   parameter int LINE_CAPACITY = ucl_pkg::LINE_CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [3:0] command, [11:4] threshold_low,
                                    // [19:12] threshold_high, [23:20] zero
);

   localparam int LEN_W = $clog2(LINE_CAPACITY);
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_CAPACITY - 1);

   // Line state
   logic [LEN_W-1:0]       line_length_ff, line_length_in;
   logic [4:0]             prefix_tracker_ff, prefix_tracker_in;
   logic [2:0]             keyword_progress_ff, keyword_progress_in;
   logic                   keyword_found_ff, keyword_found_in;
   ucl_pkg::num_phase_type number_phase_ff, number_phase_in;
   logic [7:0]             first_number_ff, first_number_in;
   logic [7:0]             second_number_ff, second_number_in;
   logic                   minus_seen_ff, minus_seen_in;
   logic                   text_ended_ff, text_ended_in;

   // Output buffer
   logic                   rsp_valid_ff, rsp_valid_in;
   ucl_pkg::result_type    rsp_data_ff, rsp_data_in;
   logic                   skid_valid_ff, skid_valid_in;
   ucl_pkg::result_type    skid_data_ff, skid_data_in;

   logic                   accept;
   logic                   rsp_fire;
   logic                   slot_free;
   logic [7:0]             rx;
   logic                   is_digit;
   logic                   is_space;
   logic                   is_sign;
   logic [2:0]             done_idx;
   logic                   done_hit;
   logic [7:0]             kw_char;
   logic [7:0]             kw_first;
   logic [2:0]             kw_next;
   logic                   res_valid;
   ucl_pkg::result_type    res_data;

   // Gather one decimal digit modulo 256
   function automatic logic [7:0] gather(input logic [7:0] acc, input logic [7:0] c);
      logic [7:0] d;
      d = c - ucl_pkg::CHAR_ZERO;
      return (acc << 3) + (acc << 1) + d;
   endfunction

   // Apply a pending minus sign
   function automatic logic [7:0] finish(input logic [7:0] v, input logic neg);
      return neg ? (8'd0 - v) : v;
   endfunction

   assign rx        = req_tdata;
   assign req_tready = ~skid_valid_ff;
   assign accept    = req_tvalid & req_tready;
   assign rsp_fire  = rsp_valid_ff & rsp_tready;
   assign slot_free = ~rsp_valid_ff | rsp_tready;

   assign is_digit = (rx >= ucl_pkg::CHAR_ZERO) && (rx <= ucl_pkg::CHAR_NINE);
   assign is_space = (rx == ucl_pkg::CHAR_SPACE) ||
                     ((rx >= ucl_pkg::CHAR_TAB) && (rx <= ucl_pkg::CHAR_CR));
   assign is_sign  = (rx == ucl_pkg::CHAR_PLUS) || (rx == ucl_pkg::CHAR_MINUS);

   // Find the first prefix completed before this byte
   always_comb begin
      done_idx = ucl_pkg::PREFIX_NONE;
      for (int i = ucl_pkg::PREFIX_COUNT - 1; i >= 0; i--) begin
         if (prefix_tracker_ff[i] &&
             line_length_ff >= LEN_W'(ucl_pkg::PREFIX_LEN[i])) begin
            done_idx = 3'(i);
         end
      end
   end
   assign done_hit = (done_idx != ucl_pkg::PREFIX_NONE);

   // Keyword characters for the current command kind
   assign kw_char  = ucl_pkg::KEYWORD_TEXT[done_idx[1:0]][keyword_progress_ff[1:0]];
   assign kw_first = ucl_pkg::KEYWORD_TEXT[done_idx[1:0]][0];
   assign kw_next  = keyword_progress_ff + 3'd1;

   // Advance line state and form a result on newline
   always_comb begin
      line_length_in      = line_length_ff;
      prefix_tracker_in   = prefix_tracker_ff;
      keyword_progress_in = keyword_progress_ff;
      keyword_found_in    = keyword_found_ff;
      number_phase_in     = number_phase_ff;
      first_number_in     = first_number_ff;
      second_number_in    = second_number_ff;
      minus_seen_in       = minus_seen_ff;
      text_ended_in       = text_ended_ff;
      res_valid           = 1'b0;
      res_data            = '0;

      if (accept && rx == ucl_pkg::CHAR_LF) begin
         // End of line: report and clear
         if (done_hit) begin
            res_valid = 1'b1;
            if (done_idx == ucl_pkg::PREFIX_THRESH) begin
               res_data.command        = ucl_pkg::CODE_SET_THRESHOLD;
               res_data.threshold_low  = first_number_ff;
               res_data.threshold_high = second_number_ff;
               if (number_phase_ff == ucl_pkg::NUM_DIGIT1) begin
                  res_data.threshold_low = finish(first_number_ff, minus_seen_ff);
               end else if (number_phase_ff == ucl_pkg::NUM_DIGIT2) begin
                  res_data.threshold_high = finish(second_number_ff, minus_seen_ff);
               end
            end else begin
               res_data.command = 4'({done_idx[1:0], ~keyword_found_ff});
            end
         end
         line_length_in      = '0;
         prefix_tracker_in   = '1;
         keyword_progress_in = '0;
         keyword_found_in    = 1'b0;
         number_phase_in     = ucl_pkg::NUM_LEAD1;
         first_number_in     = '0;
         second_number_in    = '0;
         minus_seen_in       = 1'b0;
         text_ended_in       = 1'b0;
      end else if (accept && rx != ucl_pkg::CHAR_CR && line_length_ff < LEN_LIMIT) begin
         // Keep the byte
         line_length_in = line_length_ff + 1'b1;
         if (!text_ended_ff) begin
            // Drop prefixes that this byte contradicts
            for (int i = 0; i < ucl_pkg::PREFIX_COUNT; i++) begin
               if (prefix_tracker_ff[i] &&
                   line_length_ff < LEN_W'(ucl_pkg::PREFIX_LEN[i]) &&
                   rx != ucl_pkg::PREFIX_TEXT[i][line_length_ff[3:0]]) begin
                  prefix_tracker_in[i] = 1'b0;
               end
            end
            if (rx == ucl_pkg::CHAR_NUL) begin
               text_ended_in = 1'b1;
            end else if (done_hit && done_idx != ucl_pkg::PREFIX_THRESH) begin
               // Keyword search
               if (!keyword_found_ff) begin
                  if (rx == kw_char) begin
                     keyword_progress_in = kw_next;
                     if (kw_next >= ucl_pkg::KEYWORD_LEN[done_idx[1:0]]) begin
                        keyword_found_in = 1'b1;
                     end
                  end else begin
                     keyword_progress_in = (rx == kw_first) ? 3'd1 : 3'd0;
                  end
               end
            end else if (done_idx == ucl_pkg::PREFIX_THRESH) begin
               // Two-number parse
               case (number_phase_ff)
                  ucl_pkg::NUM_LEAD1: begin
                     if (is_sign) begin
                        minus_seen_in   = (rx == ucl_pkg::CHAR_MINUS);
                        number_phase_in = ucl_pkg::NUM_SIGN1;
                     end else if (is_digit) begin
                        first_number_in = gather(first_number_ff, rx);
                        number_phase_in = ucl_pkg::NUM_DIGIT1;
                     end else if (!is_space) begin
                        number_phase_in = ucl_pkg::NUM_DONE;
                     end
                  end
                  ucl_pkg::NUM_LEAD2: begin
                     if (is_sign) begin
                        minus_seen_in   = (rx == ucl_pkg::CHAR_MINUS);
                        number_phase_in = ucl_pkg::NUM_SIGN2;
                     end else if (is_digit) begin
                        second_number_in = gather(second_number_ff, rx);
                        number_phase_in  = ucl_pkg::NUM_DIGIT2;
                     end else if (!is_space) begin
                        number_phase_in = ucl_pkg::NUM_DONE;
                     end
                  end
                  ucl_pkg::NUM_SIGN1: begin
                     if (is_digit) begin
                        first_number_in = gather(first_number_ff, rx);
                        number_phase_in = ucl_pkg::NUM_DIGIT1;
                     end else begin
                        number_phase_in = ucl_pkg::NUM_DONE;
                     end
                  end
                  ucl_pkg::NUM_SIGN2: begin
                     if (is_digit) begin
                        second_number_in = gather(second_number_ff, rx);
                        number_phase_in  = ucl_pkg::NUM_DIGIT2;
                     end else begin
                        number_phase_in = ucl_pkg::NUM_DONE;
                     end
                  end
                  ucl_pkg::NUM_DIGIT1: begin
                     if (is_digit) begin
                        first_number_in = gather(first_number_ff, rx);
                     end else begin
                        first_number_in = finish(first_number_ff, minus_seen_ff);
                        minus_seen_in   = 1'b0;
                        number_phase_in = (rx == ucl_pkg::CHAR_COLON) ?
                                          ucl_pkg::NUM_LEAD2 : ucl_pkg::NUM_DONE;
                     end
                  end
                  ucl_pkg::NUM_DIGIT2: begin
                     if (is_digit) begin
                        second_number_in = gather(second_number_ff, rx);
                     end else begin
                        second_number_in = finish(second_number_ff, minus_seen_ff);
                        minus_seen_in    = 1'b0;
                        number_phase_in  = ucl_pkg::NUM_DONE;
                     end
                  end
                  default: begin
                     number_phase_in = number_phase_ff;
                  end
               endcase
            end
         end
      end
   end

   // Output register with one skid entry
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (rsp_fire) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (slot_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = res_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = res_data;
         end
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff      <= '0;
         prefix_tracker_ff   <= '1;
         keyword_progress_ff <= '0;
         keyword_found_ff    <= 1'b0;
         number_phase_ff     <= ucl_pkg::NUM_LEAD1;
         first_number_ff     <= '0;
         second_number_ff    <= '0;
         minus_seen_ff       <= 1'b0;
         text_ended_ff       <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         skid_valid_ff       <= 1'b0;
      end else begin
         line_length_ff      <= line_length_in;
         prefix_tracker_ff   <= prefix_tracker_in;
         keyword_progress_ff <= keyword_progress_in;
         keyword_found_ff    <= keyword_found_in;
         number_phase_ff     <= number_phase_in;
         first_number_ff     <= first_number_in;
         second_number_ff    <= second_number_in;
         minus_seen_ff       <= minus_seen_in;
         text_ended_ff       <= text_ended_in;
         rsp_valid_ff        <= rsp_valid_in;
         skid_valid_ff       <= skid_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff};

   // Skid entry only fills behind a waiting result
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry valid without output register");

   // Line length stays below capacity
   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      line_length_ff <= LEN_LIMIT)
      else $error("line length beyond capacity");

   // Threshold fields are zero for non-threshold commands
   a_thresh_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.command != ucl_pkg::CODE_SET_THRESHOLD |->
      rsp_data_ff.threshold_low == 8'd0 && rsp_data_ff.threshold_high == 8'd0)
      else $error("threshold data on a non-threshold command");

   // Newline always clears the line state
   a_newline_clears: assert property (@(posedge clock) disable iff (reset)
      accept && rx == ucl_pkg::CHAR_LF |=>
      line_length_ff == '0 && prefix_tracker_ff == 5'h1F && !text_ended_ff)
      else $error("line state not cleared after newline");

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("pending result changed");

endmodule
